// ----- rtl/drc_pkg.sv -----
`default_nettype none

package drc_pkg;

    // Fixed geometry of the framebuffer and the cache
    localparam int ADDR_BITS   = 40;
    localparam int LINE_BYTES  = 64;
    localparam int PIXEL_BYTES = 3;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_ROWS    = 8192;

    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int STRIDE_BITS = 14;
    localparam int DIM_BITS    = 13;
    localparam int FCNT_BITS   = 2;
    localparam int RECT_BITS   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 40;

    localparam logic [ADDR_BITS-1:0] LINE_MASK = ~(ADDR_BITS'(LINE_BYTES - 1));

    // Register reset values
    localparam logic [ADDR_BITS-1:0]   BASE_RST   = '0;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RST = STRIDE_BITS'(3840);
    localparam logic [DIM_BITS-1:0]    WIDTH_RST  = DIM_BITS'(1280);
    localparam logic [DIM_BITS-1:0]    HEIGHT_RST = DIM_BITS'(720);
    localparam logic [FCNT_BITS-1:0]   FCNT_RST   = FCNT_BITS'(1);

    typedef enum logic [1:0] {
        KIND_DAMAGE = 2'd0,
        KIND_FLIP   = 2'd1,
        KIND_FLUSH  = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    typedef enum logic {
        ACT_FLUSH = 1'b0,
        ACT_PARK  = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASE   = 3'd0,
        CFG_STRIDE = 3'd1,
        CFG_WIDTH  = 3'd2,
        CFG_HEIGHT = 3'd3,
        CFG_FRAMES = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]           kind;
        logic [RECT_BITS-1:0] rect_x;
        logic [RECT_BITS-1:0] rect_y;
        logic [RECT_BITS-1:0] rect_w;
        logic [RECT_BITS-1:0] rect_h;
        logic                 frame;
    } t_in_item;

    typedef struct packed {
        logic                 action;
        logic [ADDR_BITS-1:0] line_addr;
        logic                 scanout_frame;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   base_addr;
        logic [STRIDE_BITS-1:0] stride_bytes;
        logic [DIM_BITS-1:0]    width_px;
        logic [DIM_BITS-1:0]    frame_height;
        logic [FCNT_BITS-1:0]   frame_count;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/drc_stream_if.sv -----
`default_nettype none

// Valid/ready channel carrying one payload per beat
interface drc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/drc_cfg_regs.sv -----
`default_nettype none

module drc_cfg_regs (
    input  wire              i_clk,
    input  wire              i_rst_n,
    drc_stream_if.sink       i_cfg,
    output drc_pkg::t_cfg    o_cfg
);

    drc_pkg::t_cfg   r_cfg;
    drc_pkg::t_cfg_wr wr;

    assign wr          = i_cfg.data;
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Take one write beat per cycle; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_addr    <= drc_pkg::BASE_RST;
            r_cfg.stride_bytes <= drc_pkg::STRIDE_RST;
            r_cfg.width_px     <= drc_pkg::WIDTH_RST;
            r_cfg.frame_height <= drc_pkg::HEIGHT_RST;
            r_cfg.frame_count  <= drc_pkg::FCNT_RST;
        end else if (i_cfg.valid) begin
            case (wr.index)
                drc_pkg::CFG_BASE:   r_cfg.base_addr    <= wr.wdata[drc_pkg::ADDR_BITS-1:0];
                drc_pkg::CFG_STRIDE: r_cfg.stride_bytes <= wr.wdata[drc_pkg::STRIDE_BITS-1:0];
                drc_pkg::CFG_WIDTH:  r_cfg.width_px     <= wr.wdata[drc_pkg::DIM_BITS-1:0];
                drc_pkg::CFG_HEIGHT: r_cfg.frame_height <= wr.wdata[drc_pkg::DIM_BITS-1:0];
                drc_pkg::CFG_FRAMES: r_cfg.frame_count  <= wr.wdata[drc_pkg::FCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/drc_out_buf.sv -----
`default_nettype none

// Two-entry result buffer; the head entry drives the output channel
module drc_out_buf (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  wire drc_pkg::t_out_item   i_item,
    output logic                      o_room,
    drc_stream_if.source              o_out
);

    logic [1:0]          r_cnt;
    drc_pkg::t_out_item  r_head;
    drc_pkg::t_out_item  r_tail;
    logic                pop;

    assign pop        = (r_cnt != 2'd0) && o_out.ready;
    assign o_room     = (r_cnt != 2'd2);
    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.data  = r_head;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case (r_cnt)
                2'd0:    if (i_push) r_cnt <= 2'd1;
                2'd1: begin
                    if (pop && !i_push) r_cnt <= 2'd0;
                    else if (!pop && i_push) r_cnt <= 2'd2;
                end
                2'd2:    if (pop) r_cnt <= 2'd1;
                default: r_cnt <= 2'd0;
            endcase
        end
    end

    // Move payload: fill head when it frees, else park the beat in tail
    always_ff @(posedge i_clk) begin
        case (r_cnt)
            2'd0:    if (i_push) r_head <= i_item;
            2'd1: begin
                if (pop && i_push) r_head <= i_item;
                else if (!pop && i_push) r_tail <= i_item;
            end
            2'd2:    if (pop) r_head <= r_tail;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/drc_core.sv -----
`default_nettype none

// Input register, damage box, flip record and flush walk
module drc_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire drc_pkg::t_in_item    i_in_item,
    output logic                      o_in_ready,
    input  wire drc_pkg::t_cfg        i_cfg,
    input  wire                       i_room,
    output logic                      o_res_valid,
    output drc_pkg::t_out_item        o_res
);

    localparam int AB = drc_pkg::ADDR_BITS;
    localparam int CB = drc_pkg::COL_BITS;
    localparam int RB = drc_pkg::ROW_BITS;
    localparam int DB = drc_pkg::DIM_BITS;
    localparam int SB = drc_pkg::STRIDE_BITS;
    localparam int XB = drc_pkg::RECT_BITS + 1;
    localparam int PB = RB + SB;
    localparam int LB = CB + 3;

    logic                r_in_valid;
    drc_pkg::t_in_item   r_in;
    logic                fire;

    logic                r_dirty;
    logic [CB-1:0]       r_box_left;
    logic [RB-1:0]       r_box_top;
    logic [CB-1:0]       r_box_right;
    logic [RB-1:0]       r_box_bottom;
    logic                r_flip_pending;
    logic                r_flip_frame;
    logic                r_walk_active;
    logic                r_walk_rows;
    logic [CB-1:0]       r_span_left;
    logic [CB-1:0]       r_span_right;
    logic [RB-1:0]       r_walk_row;
    logic [RB-1:0]       r_walk_last_row;
    logic [AB-1:0]       r_cur_addr;
    logic [AB-1:0]       r_end_addr;
    logic [1:0]          r_walk_park;

    // Hold one input beat; advance whenever the result buffer has room
    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Clip area: visible width and virtual height
    logic            eff_two;
    logic [DB-1:0]   wd;
    logic [DB-1:0]   wd_m1;
    logic [DB:0]     vh_raw;
    logic [DB:0]     vh;
    logic [DB:0]     vh_m1;
    logic            dmg_ok;
    logic [XB-1:0]   xe;
    logic [XB-1:0]   ye;
    logic [CB-1:0]   x0;
    logic [RB-1:0]   y0;
    logic [CB-1:0]   x1;
    logic [RB-1:0]   y1;
    logic            flip_ok;

    always_comb begin
        eff_two = (i_cfg.frame_count >= 2'd2);
        wd      = (i_cfg.width_px > DB'(drc_pkg::MAX_WIDTH)) ?
                  DB'(drc_pkg::MAX_WIDTH) : i_cfg.width_px;
        wd_m1   = wd - DB'(1);
        vh_raw  = eff_two ? {i_cfg.frame_height, 1'b0} : {1'b0, i_cfg.frame_height};
        vh      = (vh_raw > (DB+1)'(drc_pkg::MAX_ROWS)) ? (DB+1)'(drc_pkg::MAX_ROWS) : vh_raw;
        vh_m1   = vh - (DB+1)'(1);
        dmg_ok  = (r_in.rect_w != '0) && (r_in.rect_h != '0) &&
                  (r_in.rect_x < 16'(wd)) && (r_in.rect_y < 16'(vh));
        xe      = {1'b0, r_in.rect_x} + {1'b0, r_in.rect_w} - XB'(1);
        ye      = {1'b0, r_in.rect_y} + {1'b0, r_in.rect_h} - XB'(1);
        x0      = r_in.rect_x[CB-1:0];
        y0      = r_in.rect_y[RB-1:0];
        x1      = (xe > XB'(wd_m1)) ? wd_m1[CB-1:0] : xe[CB-1:0];
        y1      = (ye > XB'(vh_m1)) ? vh_m1[RB-1:0] : ye[RB-1:0];
        flip_ok = eff_two || (r_in.frame == 1'b0);
    end

    // Row start: first and last line of the row that begins next
    logic            is_flush;
    logic [RB-1:0]   sr_row;
    logic [CB-1:0]   sr_left;
    logic [CB-1:0]   sr_right;
    logic [PB-1:0]   prod;
    logic [CB+1:0]   left_bytes;
    logic [CB:0]     span_px;
    logic [LB-1:0]   span_len;
    logic [AB-1:0]   start_addr;
    logic [AB-1:0]   stop_addr;
    logic [AB-1:0]   row_cur;
    logic [AB-1:0]   row_end;

    always_comb begin
        is_flush   = (r_in.kind == drc_pkg::KIND_FLUSH);
        sr_row     = is_flush ? r_box_top : (r_walk_row + RB'(1));
        sr_left    = is_flush ? r_box_left : r_span_left;
        sr_right   = is_flush ? r_box_right : r_span_right;
        prod       = PB'(sr_row) * PB'(i_cfg.stride_bytes);
        left_bytes = (CB+2)'(sr_left * drc_pkg::PIXEL_BYTES);
        span_px    = {1'b0, sr_right} - {1'b0, sr_left} + (CB+1)'(1);
        span_len   = LB'(span_px * drc_pkg::PIXEL_BYTES);
        start_addr = i_cfg.base_addr + AB'(prod) + AB'(left_bytes);
        stop_addr  = start_addr + AB'(span_len) - AB'(1);
        row_cur    = start_addr & drc_pkg::LINE_MASK;
        row_end    = stop_addr & drc_pkg::LINE_MASK;
    end

    // Tick result
    logic            is_tick;
    logic            row_done;
    logic            rows_done;
    logic            fin;

    always_comb begin
        is_tick   = (r_in.kind == drc_pkg::KIND_TICK);
        row_done  = (r_cur_addr == r_end_addr);
        rows_done = row_done && (r_walk_row >= r_walk_last_row);
        fin       = rows_done && !r_walk_park[0];

        o_res_valid = fire && is_tick && r_walk_active;
        if (r_walk_rows) begin
            o_res.action        = drc_pkg::ACT_FLUSH;
            o_res.line_addr     = r_cur_addr;
            o_res.scanout_frame = 1'b0;
            o_res.last          = fin;
        end else begin
            o_res.action        = drc_pkg::ACT_PARK;
            o_res.line_addr     = '0;
            o_res.scanout_frame = r_walk_park[1];
            o_res.last          = 1'b1;
        end
    end

    // Update box, flip and walk state per beat kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty         <= 1'b0;
            r_box_left      <= '0;
            r_box_top       <= '0;
            r_box_right     <= '0;
            r_box_bottom    <= '0;
            r_flip_pending  <= 1'b0;
            r_flip_frame    <= 1'b0;
            r_walk_active   <= 1'b0;
            r_walk_rows     <= 1'b0;
            r_span_left     <= '0;
            r_span_right    <= '0;
            r_walk_row      <= '0;
            r_walk_last_row <= '0;
            r_cur_addr      <= '0;
            r_end_addr      <= '0;
            r_walk_park     <= '0;
        end else if (fire) begin
            case (r_in.kind)
                drc_pkg::KIND_DAMAGE: begin
                    if (dmg_ok) begin
                        if (r_dirty) begin
                            if (x0 < r_box_left)   r_box_left   <= x0;
                            if (y0 < r_box_top)    r_box_top    <= y0;
                            if (x1 > r_box_right)  r_box_right  <= x1;
                            if (y1 > r_box_bottom) r_box_bottom <= y1;
                        end else begin
                            r_box_left   <= x0;
                            r_box_top    <= y0;
                            r_box_right  <= x1;
                            r_box_bottom <= y1;
                            r_dirty      <= 1'b1;
                        end
                    end
                end
                drc_pkg::KIND_FLIP: begin
                    if (flip_ok) begin
                        r_flip_frame   <= r_in.frame;
                        r_flip_pending <= 1'b1;
                    end
                end
                drc_pkg::KIND_FLUSH: begin
                    if (!r_walk_active && (r_dirty || r_flip_pending)) begin
                        r_walk_active   <= 1'b1;
                        r_walk_rows     <= r_dirty;
                        r_walk_park     <= {r_flip_frame, r_flip_pending};
                        r_span_left     <= r_box_left;
                        r_span_right    <= r_box_right;
                        r_walk_row      <= r_box_top;
                        r_walk_last_row <= r_box_bottom;
                        r_dirty         <= 1'b0;
                        r_flip_pending  <= 1'b0;
                        if (r_dirty) begin
                            r_cur_addr <= row_cur;
                            r_end_addr <= row_end;
                        end
                    end
                end
                drc_pkg::KIND_TICK: begin
                    if (r_walk_active) begin
                        if (r_walk_rows) begin
                            if (row_done) begin
                                if (rows_done) begin
                                    r_walk_rows <= 1'b0;
                                    if (fin) r_walk_active <= 1'b0;
                                end else begin
                                    r_walk_row <= r_walk_row + RB'(1);
                                    r_cur_addr <= row_cur;
                                    r_end_addr <= row_end;
                                end
                            end else begin
                                r_cur_addr <= r_cur_addr + AB'(drc_pkg::LINE_BYTES);
                            end
                        end else begin
                            r_walk_park   <= '0;
                            r_walk_active <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dirty_rect_cache_flush.sv -----
// A result is computed from the input register and registered in the result buffer.
// Throughput: one input beat per cycle while the result buffer has room; the
// row address step (one row-by-stride multiply plus adds) is combinational.
// A two-entry result buffer keeps input flowing while a result waits.
// Reset (synchronous, active low) clears box, flip and walk state and loads
// the register defaults; the block accepts beats in the first cycle after it.
`default_nettype none

module dirty_rect_cache_flush (
    input  wire          i_clk,
    input  wire          i_rst_n,
    drc_stream_if.sink   i_in,
    drc_stream_if.sink   i_cfg,
    drc_stream_if.source o_out
);

    drc_pkg::t_cfg       cfg;
    drc_pkg::t_out_item  res;
    logic                res_valid;
    logic                room;

    drc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    drc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_item   (i_in.data),
        .o_in_ready  (i_in.ready),
        .i_cfg       (cfg),
        .i_room      (room),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    drc_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
